// File: rtl/core/nmtc_pkg.sv
// ----------------------------------------------------------------------------
// nmtc_pkg: shared types and constants for the name match tier classifier
// Request and tier codes, character constants and the control and hit
// bundles that travel between the top level and the cell chain.
// ----------------------------------------------------------------------------
package nmtc_pkg;

  // Default sizes
  localparam int QUERY_MAX_DEF = 64;
  localparam int CHAR_BITS_DEF = 16;

  // Field widths fixed by the interface
  localparam int REQ_W  = 2;
  localparam int TIER_W = 3;
  localparam int STEM_W = 10;

  localparam logic [STEM_W-1:0] STEM_MAX = '1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_NAME   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_END    = 2'd3;

  // Tier codes
  localparam logic [TIER_W-1:0] TIER_NONE      = 3'd0;
  localparam logic [TIER_W-1:0] TIER_SUBSTRING = 3'd1;
  localparam logic [TIER_W-1:0] TIER_WORD      = 3'd2;
  localparam logic [TIER_W-1:0] TIER_PREFIX    = 3'd3;
  localparam logic [TIER_W-1:0] TIER_EXACT     = 3'd4;

  // Characters
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // Per-word controls broadcast to every cell, already qualified by accept
  typedef struct packed {
    logic clear_query;
    logic name_reset;
    logic append;
    logic name_char;
  } nmtc_ctrl_t;

  // Per-cell or reduced hit flags for the current name character
  typedef struct packed {
    logic sub_hit;
    logic wp_hit;
    logic kill;
  } nmtc_hit_t;

endpackage

// File: rtl/core/nmtc_cell.sv
// ----------------------------------------------------------------------------
// nmtc_cell: one query position of the match chain
// Holds one folded query character, its occupied bit, the substring and
// word prefix match bits and the prefix position token.
// ----------------------------------------------------------------------------
module nmtc_cell
  import nmtc_pkg::*;
#(
  parameter int  CHAR_BITS = CHAR_BITS_DEF,
  parameter bit  FIRST     = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nmtc_ctrl_t           ctrl,
  input  logic [CHAR_BITS-1:0] ch_fold,
  input  logic                 prev_active,
  input  logic                 next_active,
  input  logic                 prev_sub,
  input  logic                 prev_wp,
  input  logic                 prev_token,
  output logic                 active,
  output logic                 sub,
  output logic                 wp,
  output logic                 token,
  output nmtc_hit_t            hit
);

  logic [CHAR_BITS-1:0] qch;
  logic                 match;
  logic                 sub_next;
  logic                 wp_next;
  logic                 last;

  // Compare this position against the incoming character
  assign match    = active && (qch == ch_fold);
  assign sub_next = prev_sub && match;
  assign wp_next  = prev_wp && match;
  assign last     = active && !next_active;

  assign hit.sub_hit = sub_next && last;
  assign hit.wp_hit  = wp_next && last;
  assign hit.kill    = token && active && !match;

  // Capture the query character at the first free position
  always_ff @(posedge clk) begin
    if (ctrl.append && !active && prev_active) begin
      qch <= ch_fold;
    end
  end

  // Advance occupancy and match state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      sub    <= 1'b0;
      wp     <= 1'b0;
      token  <= FIRST;
    end else begin
      if (ctrl.clear_query) begin
        active <= 1'b0;
      end else if (ctrl.append) begin
        active <= active || prev_active;
      end
      if (ctrl.name_reset) begin
        sub   <= 1'b0;
        wp    <= 1'b0;
        token <= FIRST;
      end else if (ctrl.name_char) begin
        sub   <= sub_next;
        wp    <= wp_next;
        token <= prev_token;
      end
    end
  end

endmodule

// File: rtl/core/nmtc_chain.sv
// ----------------------------------------------------------------------------
// nmtc_chain: row of query cells
// Links the cells neighbor to neighbor and folds their hit flags into one
// set for the current name character.
// ----------------------------------------------------------------------------
module nmtc_chain
  import nmtc_pkg::*;
#(
  parameter int QUERY_MAX = QUERY_MAX_DEF,
  parameter int CHAR_BITS = CHAR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nmtc_ctrl_t           ctrl,
  input  logic [CHAR_BITS-1:0] ch_fold,
  input  logic                 after_break,
  output logic                 full,
  output nmtc_hit_t            hit
);

  logic [QUERY_MAX-1:0] active;
  logic [QUERY_MAX-1:0] sub;
  logic [QUERY_MAX-1:0] wp;
  logic [QUERY_MAX-1:0] token;
  logic [QUERY_MAX-1:0] sub_hit;
  logic [QUERY_MAX-1:0] wp_hit;
  logic [QUERY_MAX-1:0] kill;

  // Build the row; the first cell takes the injected run starts
  for (genvar k = 0; k < QUERY_MAX; k++) begin : g_cell
    logic      p_active;
    logic      n_active;
    logic      p_sub;
    logic      p_wp;
    logic      p_token;
    nmtc_hit_t h;

    if (k == 0) begin : g_head
      assign p_active = 1'b1;
      assign p_sub    = 1'b1;
      assign p_wp     = after_break;
      assign p_token  = 1'b0;
    end else begin : g_body
      assign p_active = active[k-1];
      assign p_sub    = sub[k-1];
      assign p_wp     = wp[k-1];
      assign p_token  = token[k-1];
    end

    if (k == QUERY_MAX - 1) begin : g_tail
      assign n_active = 1'b0;
    end else begin : g_mid
      assign n_active = active[k+1];
    end

    nmtc_cell #(
      .CHAR_BITS (CHAR_BITS),
      .FIRST     (k == 0)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .ch_fold     (ch_fold),
      .prev_active (p_active),
      .next_active (n_active),
      .prev_sub    (p_sub),
      .prev_wp     (p_wp),
      .prev_token  (p_token),
      .active      (active[k]),
      .sub         (sub[k]),
      .wp          (wp[k]),
      .token       (token[k]),
      .hit         (h)
    );

    assign sub_hit[k] = h.sub_hit;
    assign wp_hit[k]  = h.wp_hit;
    assign kill[k]    = h.kill;
  end

  // Reduce the hit flags across the row
  assign hit.sub_hit = |sub_hit;
  assign hit.wp_hit  = |wp_hit;
  assign hit.kill    = |kill;
  assign full        = active[QUERY_MAX-1];

endmodule

// File: rtl/core/name_match_tier_classifier_core.sv
// ----------------------------------------------------------------------------
// name_match_tier_classifier_core: query loader and name match classifier
// Loads a query, streams file names and reports the best match tier and the
// stem length at the end of each name.
//
//   channel  | signals                                  | dir
//   ---------+------------------------------------------+-----
//   request  | in_valid, in_ready, req_type, ch         | in
//   result   | out_valid, out_ready, tier, stem_chars,  | out
//            | query_truncated                          |
//
// The cell row updates all query positions in parallel, so one word is
// accepted per cycle whenever in_ready is high.
// An end-of-name word produces its result in the output register on the
// next cycle; other words produce nothing.
// A held result stalls the request side only while out_ready is low.
// Reset empties the query and clears all name state; no clearing pass.
// ----------------------------------------------------------------------------
module name_match_tier_classifier_core
  import nmtc_pkg::*;
#(
  parameter int QUERY_MAX = QUERY_MAX_DEF,
  parameter int CHAR_BITS = CHAR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [CHAR_BITS-1:0] ch,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TIER_W-1:0]    tier,
  output logic [STEM_W-1:0]    stem_chars,
  output logic                 query_truncated
);

  localparam int LEN_W = $clog2(QUERY_MAX + 1);
  localparam int POS_W = $clog2(QUERY_MAX + 2);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(QUERY_MAX);
  localparam logic [POS_W-1:0] POS_SAT = POS_W'(QUERY_MAX + 1);

  logic                 accept;
  logic                 is_clear;
  logic                 is_append;
  logic                 is_name;
  logic                 is_end;
  logic [CHAR_BITS-1:0] ch_fold;
  logic                 is_upper;
  logic                 is_brk;
  logic                 is_dot;
  nmtc_ctrl_t           ctrl;
  nmtc_hit_t            hit;
  logic                 full;

  logic [LEN_W-1:0]     qlen;
  logic                 truncated;
  logic [POS_W-1:0]     pos;
  logic                 alive;
  logic                 alive_next;
  logic [1:0]           found;
  logic                 stem_match;
  logic                 dot_seen;
  logic [STEM_W-1:0]    stem;
  logic                 after_break;
  logic [TIER_W-1:0]    tier_next;
  logic [POS_W-1:0]     qlen_ext;

  // Handshake: take a word whenever the output register can move
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Decode the request
  always_comb begin
    is_clear  = 1'b0;
    is_append = 1'b0;
    is_name   = 1'b0;
    is_end    = 1'b0;
    unique case (req_type)
      REQ_CLEAR:  is_clear  = 1'b1;
      REQ_APPEND: is_append = 1'b1;
      REQ_NAME:   is_name   = 1'b1;
      REQ_END:    is_end    = 1'b1;
      default:    is_clear  = 1'b0;
    endcase
  end

  // Fold ASCII upper case and classify the character
  assign is_upper = (ch >= CHAR_BITS'(CH_UPPER_A)) && (ch <= CHAR_BITS'(CH_UPPER_Z));
  assign ch_fold  = is_upper ? ch + CHAR_BITS'(CASE_DELTA) : ch;
  assign is_dot   = (ch == CHAR_BITS'(CH_DOT));
  assign is_brk   = is_dot || (ch == CHAR_BITS'(CH_SPACE)) || (ch == CHAR_BITS'(CH_DASH))
                 || (ch == CHAR_BITS'(CH_UNDER)) || (ch == CHAR_BITS'(CH_PLUS));

  assign ctrl.clear_query = accept && is_clear;
  assign ctrl.append      = accept && is_append;
  assign ctrl.name_char   = accept && is_name;
  assign ctrl.name_reset  = accept && (is_clear || is_append || is_end);

  nmtc_chain #(
    .QUERY_MAX (QUERY_MAX),
    .CHAR_BITS (CHAR_BITS)
  ) u_chain (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .ch_fold     (ch_fold),
    .after_break (after_break),
    .full        (full),
    .hit         (hit)
  );

  assign qlen_ext   = POS_W'(qlen);
  assign alive_next = alive && !hit.kill;

  // Pick the best tier for the name that ends now
  always_comb begin
    tier_next = TIER_NONE;
    if (qlen != '0) begin
      if ((alive && pos == qlen_ext) || stem_match) begin
        tier_next = TIER_EXACT;
      end else if (alive && pos >= qlen_ext) begin
        tier_next = TIER_PREFIX;
      end else if (found[1]) begin
        tier_next = TIER_WORD;
      end else if (found[0]) begin
        tier_next = TIER_SUBSTRING;
      end
    end
  end

  // Query length and truncation
  always_ff @(posedge clk) begin
    if (rst) begin
      qlen      <= '0;
      truncated <= 1'b0;
    end else if (ctrl.clear_query) begin
      qlen      <= '0;
      truncated <= 1'b0;
    end else if (ctrl.append) begin
      if (full || qlen == LEN_MAX) begin
        truncated <= 1'b1;
      end else begin
        qlen <= qlen + LEN_W'(1);
      end
    end
  end

  // Name state: position, prefix, stem and break tracking
  always_ff @(posedge clk) begin
    if (rst || ctrl.name_reset) begin
      pos         <= '0;
      alive       <= 1'b1;
      found       <= 2'b00;
      stem_match  <= 1'b0;
      dot_seen    <= 1'b0;
      stem        <= '0;
      after_break <= 1'b0;
    end else if (ctrl.name_char) begin
      alive <= alive_next;
      if (pos != POS_SAT) begin
        pos <= pos + POS_W'(1);
      end
      if (!dot_seen) begin
        if (is_dot) begin
          dot_seen   <= 1'b1;
          stem_match <= alive_next && (pos == qlen_ext);
        end else if (stem != STEM_MAX) begin
          stem <= stem + STEM_W'(1);
        end
      end
      found       <= found | {hit.wp_hit, hit.sub_hit};
      after_break <= is_brk;
    end
  end

  // Output register: load on end of name, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && is_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_end) begin
      tier            <= tier_next;
      stem_chars      <= stem;
      query_truncated <= truncated;
    end
  end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for name_match_tier_classifier_core
// Loads queries and streams file names through the request channel. A
// tracking model of the classifier predicts the tier, stem length and
// truncation flag of every end-of-name word. A checker compares each result
// word with the oldest prediction. Both channels idle and stall in random
// bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
module testbench;
  import nmtc_pkg::*;

  localparam int QMAX         = QUERY_MAX_DEF;
  localparam int CW           = CHAR_BITS_DEF;
  localparam int NAME_POS_CAP = 2047;

  typedef struct packed {
    logic [TIER_W-1:0] tier;
    logic [STEM_W-1:0] stem;
    logic              trunc;
  } tier_report_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [REQ_W-1:0]  req_type = REQ_CLEAR;
  logic [CW-1:0]     ch = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [TIER_W-1:0] tier;
  logic [STEM_W-1:0] stem_chars;
  logic              query_truncated;

  name_match_tier_classifier_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .ch             (ch),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tier           (tier),
    .stem_chars     (stem_chars),
    .query_truncated(query_truncated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Tracked classifier state
  logic [CW-1:0]   q_store [QMAX];
  int              q_len;
  logic            q_dropped;
  logic [QMAX-1:0] sub_run;
  logic [QMAX-1:0] wp_run;
  logic [1:0]      hits;
  int              name_pos;
  logic            name_alive;
  logic            stem_equal;
  logic            dot_hit;
  int              stem_count;
  logic            prev_break;

  tier_report_t pending_reports [$];
  tier_report_t head_report;
  int           errors = 0;
  int           words_sent = 0;
  bit           idle_on = 1'b1;
  int           stall_left = 0;

  function automatic logic [CW-1:0] fold_upper(logic [CW-1:0] c);
    if (c >= {8'h00, CH_UPPER_A} && c <= {8'h00, CH_UPPER_Z}) return c + {8'h00, CASE_DELTA};
    return c;
  endfunction

  function automatic bit chars_equal(logic [CW-1:0] a, logic [CW-1:0] b);
    return fold_upper(a) == fold_upper(b);
  endfunction

  function automatic bit is_separator(logic [CW-1:0] c);
    return c == {8'h00, CH_SPACE} || c == {8'h00, CH_DASH} || c == {8'h00, CH_UNDER} ||
           c == {8'h00, CH_DOT} || c == {8'h00, CH_PLUS};
  endfunction

  // Shift one name character through a run vector; bit k tracks query[0..k]
  function automatic logic [QMAX-1:0] shift_run(logic [QMAX-1:0] v, logic seed,
                                                logic [CW-1:0] c);
    logic [QMAX-1:0] nv;
    logic            prev;
    nv = v;
    for (int i = 0; i < QMAX; i++) begin
      if (i < q_len) begin
        prev  = (i == 0) ? seed : v[i-1];
        nv[i] = prev && chars_equal(c, q_store[i]);
      end
    end
    return nv;
  endfunction

  task automatic clear_name_state();
    sub_run    = '0;
    wp_run     = '0;
    hits       = '0;
    name_pos   = 0;
    name_alive = 1'b1;
    stem_equal = 1'b0;
    dot_hit    = 1'b0;
    stem_count = 0;
    prev_break = 1'b0;
  endtask

  // Update the tracked state for one accepted word; queue a report on end
  task automatic classify_word(logic [REQ_W-1:0] t, logic [CW-1:0] c);
    tier_report_t rep;
    case (t)
      REQ_CLEAR: begin
        q_len     = 0;
        q_dropped = 1'b0;
        clear_name_state();
      end
      REQ_APPEND: begin
        if (q_len < QMAX) begin
          q_store[q_len] = c;
          q_len++;
        end else begin
          q_dropped = 1'b1;
        end
        clear_name_state();
      end
      REQ_NAME: begin
        if (name_pos < q_len && !chars_equal(c, q_store[name_pos])) name_alive = 1'b0;
        if (!dot_hit) begin
          if (c == {8'h00, CH_DOT}) begin
            dot_hit    = 1'b1;
            stem_equal = name_alive && name_pos == q_len;
          end else if (stem_count < STEM_MAX) begin
            stem_count++;
          end
        end
        sub_run = shift_run(sub_run, 1'b1, c);
        if (q_len > 0 && sub_run[q_len-1]) hits[0] = 1'b1;
        wp_run = shift_run(wp_run, prev_break, c);
        if (q_len > 0 && wp_run[q_len-1]) hits[1] = 1'b1;
        prev_break = is_separator(c);
        if (name_pos < NAME_POS_CAP) name_pos++;
      end
      default: begin
        rep.tier = TIER_NONE;
        if (q_len > 0) begin
          if ((name_alive && name_pos == q_len) || stem_equal) rep.tier = TIER_EXACT;
          else if (name_alive && name_pos >= q_len) rep.tier = TIER_PREFIX;
          else if (hits[1]) rep.tier = TIER_WORD;
          else if (hits[0]) rep.tier = TIER_SUBSTRING;
        end
        rep.stem  = STEM_W'(stem_count);
        rep.trunc = q_dropped;
        pending_reports.push_back(rep);
        clear_name_state();
      end
    endcase
  endtask

  // Send one request word; called at a rising edge, returns at its accept edge
  task automatic send_word(logic [REQ_W-1:0] t, logic [CW-1:0] c);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= t;
    ch       <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    classify_word(t, c);
    words_sent++;
  endtask

  task automatic load_query(string s);
    send_word(REQ_CLEAR, CW'($urandom));
    for (int i = 0; i < s.len(); i++) send_word(REQ_APPEND, {8'h00, s[i]});
  endtask

  task automatic send_name(string s);
    for (int i = 0; i < s.len(); i++) send_word(REQ_NAME, {8'h00, s[i]});
    send_word(REQ_END, CW'($urandom));
  endtask

  function automatic logic [CW-1:0] pick_separator();
    case ($urandom_range(0, 4))
      0:       return {8'h00, CH_SPACE};
      1:       return {8'h00, CH_DASH};
      2:       return {8'h00, CH_UNDER};
      3:       return {8'h00, CH_DOT};
      default: return {8'h00, CH_PLUS};
    endcase
  endfunction

  // Mostly a small letter set so that matches are common
  function automatic logic [CW-1:0] random_char();
    int            r;
    logic [CW-1:0] c;
    r = $urandom_range(0, 19);
    if (r < 13) begin
      c = 16'h61 + 16'($urandom_range(0, 2));
      if ($urandom_range(0, 1) == 1) c = c - {8'h00, CASE_DELTA};
    end else if (r < 18) begin
      c = pick_separator();
    end else if (r == 18) begin
      c = 16'($urandom_range(0, 65535));
    end else begin
      c = '0;
    end
    return c;
  endfunction

  function automatic logic [CW-1:0] flip_case(logic [CW-1:0] c);
    if (c >= {8'h00, CH_UPPER_A} && c <= {8'h00, CH_UPPER_Z}) return c + {8'h00, CASE_DELTA};
    if (c >= ({8'h00, CH_UPPER_A} + 16'h20) && c <= ({8'h00, CH_UPPER_Z} + 16'h20))
      return c - {8'h00, CASE_DELTA};
    return c;
  endfunction

  // Each tier in turn, every separator, stem match past a dot
  task automatic test_tier_order();
    load_query("Ab");
    send_name("ab");
    send_name("aB.txt");
    send_name("abc");
    send_name("x_ab");
    send_name("c+AB");
    send_name("x.ab");
    send_name("x ab");
    send_name("x-ab");
    send_name("xaby");
    send_name("a");
    send_name("");
    send_name("ab.ab");
    send_name("a.b");
  endtask

  // Empty query never matches but still counts the stem
  task automatic test_empty_query();
    send_word(REQ_CLEAR, 16'hFFFF);
    send_name("abc");
    send_name("x.y");
    send_name("");
  endtask

  // Fold only A-Z; neighbors of the letter ranges and wide codes stay apart
  task automatic test_case_folding();
    load_query("@[z`{");
    send_name("@[Z`{");
    send_name("`{z@[");
    send_word(REQ_CLEAR, 16'h0000);
    send_word(REQ_APPEND, 16'h0141);
    send_word(REQ_APPEND, 16'h0062);
    send_word(REQ_APPEND, 16'hFFFF);
    send_word(REQ_NAME, 16'h0141);
    send_word(REQ_NAME, 16'h0042);
    send_word(REQ_NAME, 16'hFFFF);
    send_word(REQ_END, 16'h0000);
    send_word(REQ_NAME, 16'h0161);
    send_word(REQ_NAME, 16'h0062);
    send_word(REQ_NAME, 16'hFFFF);
    send_word(REQ_END, 16'hFFFF);
    send_word(REQ_NAME, 16'h0041);
    send_word(REQ_NAME, 16'h0062);
    send_word(REQ_END, 16'h5555);
  endtask

  // Zero character compares like any other
  task automatic test_zero_char();
    send_word(REQ_CLEAR, 16'h0000);
    send_word(REQ_APPEND, 16'h0000);
    send_word(REQ_APPEND, 16'h0061);
    send_word(REQ_NAME, 16'h0000);
    send_word(REQ_NAME, 16'h0041);
    send_word(REQ_END, 16'h0000);
    send_name("a");
    send_word(REQ_NAME, 16'h0078);
    send_word(REQ_NAME, 16'h0000);
    send_word(REQ_NAME, 16'h0061);
    send_word(REQ_END, 16'h0000);
  endtask

  // Fill the store, overflow it, match on the last position
  task automatic test_full_store();
    logic [CW-1:0] c;
    send_word(REQ_CLEAR, 16'h0000);
    for (int i = 0; i < QMAX + 2; i++) begin
      c = 16'h61 + 16'(i % 26);
      if (i % 2 == 0) c = c - {8'h00, CASE_DELTA};
      send_word(REQ_APPEND, c);
    end
    for (int n = 0; n < 4; n++) begin
      if (n == 2) send_word(REQ_NAME, 16'h0078);
      if (n == 3) send_word(REQ_NAME, {8'h00, CH_DASH});
      for (int i = 0; i < ((n == 1) ? QMAX - 1 : QMAX); i++)
        send_word(REQ_NAME, 16'h61 + 16'(i % 26));
      send_word(REQ_END, 16'h0000);
    end
    send_word(REQ_CLEAR, 16'h0000);
    send_name("ab");
  endtask

  // Query changes in the middle of a name drop the partial name
  task automatic test_name_interrupt();
    load_query("ab");
    send_word(REQ_NAME, 16'h0061);
    send_word(REQ_NAME, 16'h0062);
    send_word(REQ_APPEND, 16'h0063);
    send_name("abc");
    send_word(REQ_NAME, 16'h0078);
    send_word(REQ_NAME, 16'h002E);
    send_word(REQ_CLEAR, 16'h0000);
    send_name("");
  endtask

  // Mostly query loads and names built around the query, with some noise
  task automatic test_random_traffic(int n_words, bit allow_idle);
    logic [CW-1:0] q_text [$];
    logic [CW-1:0] nm [$];
    logic [CW-1:0] c;
    int            start;
    int            r;
    int            form;
    int            qn;
    int            keep;
    bit            need_reload;
    start       = words_sent;
    need_reload = 1'b1;
    while (words_sent - start < n_words) begin
      idle_on = allow_idle && ($urandom_range(0, 4) != 0);
      r = $urandom_range(0, 19);
      if (r == 0) begin
        // noise: random types and wide characters
        repeat ($urandom_range(1, 6)) send_word(REQ_W'($urandom), CW'($urandom));
        need_reload = 1'b1;
      end else if (r <= 3 || need_reload) begin
        // load a new query, rarely long enough to overflow
        if ($urandom_range(0, 9) == 0) qn = $urandom_range(0, QMAX + 2);
        else qn = $urandom_range(1, 6);
        q_text.delete();
        send_word(REQ_CLEAR, CW'($urandom));
        for (int i = 0; i < qn; i++) begin
          c = random_char();
          if (q_text.size() < QMAX) q_text.push_back(c);
          send_word(REQ_APPEND, c);
        end
        need_reload = 1'b0;
      end else begin
        // build one name around the query
        nm.delete();
        form = $urandom_range(0, 6);
        if (form == 3 || form == 4)
          repeat ($urandom_range(0, 3)) nm.push_back(random_char());
        if (form == 3) nm.push_back(pick_separator());
        keep = (form == 6) ? $urandom_range(0, q_text.size()) :
               (form == 5) ? 0 : q_text.size();
        for (int i = 0; i < keep; i++)
          nm.push_back(($urandom_range(0, 2) == 0) ? flip_case(q_text[i]) : q_text[i]);
        if (form == 1) nm.push_back({8'h00, CH_DOT});
        if (form != 0) repeat ($urandom_range(0, (form == 5) ? 8 : 4)) nm.push_back(random_char());
        foreach (nm[i]) send_word(REQ_NAME, nm[i]);
        if ($urandom_range(0, 24) == 0) begin
          send_word(($urandom_range(0, 1) == 0) ? REQ_CLEAR : REQ_APPEND, random_char());
          need_reload = 1'b1;
        end else begin
          send_word(REQ_END, CW'($urandom));
        end
      end
    end
  endtask

  // Drive result-side stalls in random bursts
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each accepted result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result: tier %0d stem %0d trunc %0d", $time, tier,
                 stem_chars, query_truncated);
        errors++;
      end else begin
        head_report = pending_reports.pop_front();
        if (tier !== head_report.tier) begin
          $display("%0t: tier expected %0d actual %0d", $time, head_report.tier, tier);
          errors++;
        end
        if (stem_chars !== head_report.stem) begin
          $display("%0t: stem_chars expected %0d actual %0d", $time, head_report.stem,
                   stem_chars);
          errors++;
        end
        if (query_truncated !== head_report.trunc) begin
          $display("%0t: query_truncated expected %0d actual %0d", $time, head_report.trunc,
                   query_truncated);
          errors++;
        end
      end
    end
  end

  initial begin
    q_len     = 0;
    q_dropped = 1'b0;
    foreach (q_store[i]) q_store[i] = '0;
    clear_name_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_tier_order();
    test_empty_query();
    test_case_folding();
    test_zero_char();
    test_full_store();
    test_name_interrupt();
    test_random_traffic(540, 1'b1);
    test_random_traffic(120, 1'b0);

    // Drain: wait for every report, then let the pipeline settle
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_reports.size() != 0) errors++;
    if (errors == 0) begin
      $display("[name_match_tier_classifier_core] OK");
    end else begin
      $display("[name_match_tier_classifier_core] ERROR");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #1000000;
    $display("[name_match_tier_classifier_core] ERROR");
    $finish;
  end

endmodule
